// File: hdl/mtee_pkg.sv
// Shared types, constants and helper functions for the MIDI track event encoder.
// Used by every module in this folder; depends on nothing else.
package mtee_pkg;

   localparam int TIME_W    = 16;
   localparam int TPS_W     = 10;
   localparam int TEMPO_W   = 24;
   localparam int VEL_W     = 7;
   localparam int CHAN_W    = 4;
   localparam int PITCH_W   = 7;
   localparam int TICK_W    = 32;
   localparam int VLQ_W     = 21;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   localparam int TIME_FRAC_BITS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF    = 4;

   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;
   localparam logic [TPS_W-1:0]   TPS_RESET   = 10'd192;
   localparam logic [VEL_W-1:0]   VEL_RESET   = 7'd100;
   localparam logic [CHAN_W-1:0]  CHAN_RESET  = 4'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TPS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN  = 2'd3;

   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [7:0] META_PREFIX     = 8'hFF;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] META_EOT        = 8'h2F;
   localparam logic [7:0] TEMPO_DATA_LEN  = 8'h03;
   localparam logic [7:0] ZERO_BYTE       = 8'h00;

   localparam logic [TICK_W-1:0] VLQ_ONE_LIMIT = 32'h0000_0080;
   localparam logic [TICK_W-1:0] VLQ_TWO_LIMIT = 32'h0000_4000;

   typedef struct packed {
      logic [PITCH_W-1:0] note_pitch;
      logic [TIME_W-1:0]  start_time;
      logic [TIME_W-1:0]  note_length;
      logic               final_note;
   } req_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              last_of_run;
      logic              track_done;
      logic [TICK_W-1:0] track_length;
   } rsp_type;

   typedef struct packed {
      logic [TEMPO_W-1:0] tempo;
      logic [VEL_W-1:0]   velocity;
      logic [CHAN_W-1:0]  channel;
   } cfg_type;

   // One classified note waiting for the byte sequencer.
   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic               fin;
      logic               tempo_first;
      logic [VLQ_W-1:0]   delta;
      logic [1:0]         delta_len;
      logic [VLQ_W-1:0]   dur;
      logic [1:0]         dur_len;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Number of 7-bit groups used for a delta; at most three.
   function automatic logic [1:0] vlq_len(input logic [TICK_W-1:0] v);
      logic [1:0] n;
      if (v < VLQ_ONE_LIMIT) begin
         n = 2'd1;
      end else if (v < VLQ_TWO_LIMIT) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

   // Byte idx of a delta of len groups, most significant group first.
   function automatic logic [7:0] vlq_byte(input logic [VLQ_W-1:0] v,
                                           input logic [1:0] len,
                                           input logic [2:0] idx);
      logic [1:0] g;
      logic [7:0] b;
      g = len - 2'd1 - idx[1:0];
      case (g)
         2'd1: begin
            b = {1'b1, v[13:7]};
         end
         2'd2: begin
            b = {1'b1, v[20:14]};
         end
         default: begin
            b = {1'b0, v[6:0]};
         end
      endcase
      return b;
   endfunction

endpackage

// File: hdl/mtee_front.sv
// Front end: accepts notes, scales both times to ticks and builds a job with
// the delta from the running tick. Depends on mtee_pkg.
module mtee_front
   import mtee_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic [TPS_W-1:0] ticks_per_second,
   input  q_status_type     q_status,
   output logic             push,
   output job_type          push_job
);

   localparam int PROD_W = TIME_W + TPS_W;

   logic               s1_valid_ff, s1_valid_in;
   logic [PITCH_W-1:0] s1_pitch_ff, s1_pitch_in;
   logic [TICK_W-1:0]  s1_start_ff, s1_start_in;
   logic [TICK_W-1:0]  s1_dur_ff, s1_dur_in;
   logic               s1_fin_ff, s1_fin_in;
   logic [TICK_W-1:0]  cur_tick_ff, cur_tick_in;
   logic               tempo_pending_ff, tempo_pending_in;

   logic [PROD_W-1:0]  start_prod, dur_prod;
   logic [TICK_W-1:0]  delta_full;
   logic               s1_adv;

   assign s1_adv    = !s1_valid_ff || !q_status.full;
   assign req_stall = !s1_adv;
   assign push      = s1_valid_ff && !q_status.full;

   assign start_prod = {{TPS_W{1'b0}}, req_data.start_time} *
                       {{TIME_W{1'b0}}, ticks_per_second};
   assign dur_prod   = {{TPS_W{1'b0}}, req_data.note_length} *
                       {{TIME_W{1'b0}}, ticks_per_second};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pitch_in = s1_pitch_ff;
      s1_start_in = s1_start_ff;
      s1_dur_in   = s1_dur_ff;
      s1_fin_in   = s1_fin_ff;
      if (s1_adv) begin
         s1_valid_in = req_valid;
         s1_pitch_in = req_data.note_pitch;
         s1_start_in = TICK_W'(start_prod >> TIME_FRAC_BITS);
         s1_dur_in   = TICK_W'(dur_prod >> TIME_FRAC_BITS);
         s1_fin_in   = req_data.final_note;
      end
   end

   // The delta wraps modulo 2^32 when a note starts before the running tick.
   assign delta_full = s1_start_ff - cur_tick_ff;

   always_comb begin
      push_job.pitch       = s1_pitch_ff;
      push_job.fin         = s1_fin_ff;
      push_job.tempo_first = tempo_pending_ff;
      push_job.delta       = delta_full[VLQ_W-1:0];
      push_job.delta_len   = vlq_len(delta_full);
      push_job.dur         = s1_dur_ff[VLQ_W-1:0];
      push_job.dur_len     = vlq_len(s1_dur_ff);
   end

   always_comb begin
      cur_tick_in      = cur_tick_ff;
      tempo_pending_in = tempo_pending_ff;
      if (push) begin
         cur_tick_in      = s1_fin_ff ? '0 : s1_start_ff + s1_dur_ff;
         tempo_pending_in = s1_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         cur_tick_ff      <= '0;
         tempo_pending_ff <= 1'b1;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         cur_tick_ff      <= cur_tick_in;
         tempo_pending_ff <= tempo_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pitch_ff <= s1_pitch_in;
      s1_start_ff <= s1_start_in;
      s1_dur_ff   <= s1_dur_in;
      s1_fin_ff   <= s1_fin_in;
   end

endmodule

// File: hdl/mtee_queue.sv
// Short job queue between the front end and the byte sequencer.
// Depends on mtee_pkg for the job type.
module mtee_queue
   import mtee_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hdl/mtee_back.sv
// Byte sequencer: walks each job's event bytes into the result register, one
// per unstalled cycle, and counts the track bytes. Depends on mtee_pkg.
module mtee_back
   import mtee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   input  job_type      head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [5:0] {
      ST_TEMPO    = 6'b000001,
      ST_DELTA    = 6'b000010,
      ST_NOTE_ON  = 6'b000100,
      ST_DUR      = 6'b001000,
      ST_NOTE_OFF = 6'b010000,
      ST_EOT      = 6'b100000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [2:0]        idx_ff, idx_in;
   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [TICK_W-1:0] bytes_sent_ff, bytes_sent_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              out_free, emit, last_byte, done_byte;
   logic [7:0]        cur_byte;
   seq_state_type     step_state;
   logic [2:0]        step_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign pop      = !q_status.empty && (!busy_ff || (emit && last_byte));

   // Byte selection and the step to the next byte of the job.
   always_comb begin
      cur_byte   = ZERO_BYTE;
      step_state = state_ff;
      step_idx   = idx_ff + 3'd1;
      last_byte  = 1'b0;
      done_byte  = 1'b0;
      case (state_ff)
         ST_TEMPO: begin
            case (idx_ff)
               3'd0: cur_byte = ZERO_BYTE;
               3'd1: cur_byte = META_PREFIX;
               3'd2: cur_byte = META_TEMPO;
               3'd3: cur_byte = TEMPO_DATA_LEN;
               3'd4: cur_byte = cfg.tempo[23:16];
               3'd5: cur_byte = cfg.tempo[15:8];
               default: cur_byte = cfg.tempo[7:0];
            endcase
            if (idx_ff == 3'd6) begin
               step_state = ST_DELTA;
               step_idx   = '0;
            end
         end
         ST_DELTA: begin
            cur_byte = vlq_byte(job_ff.delta, job_ff.delta_len, idx_ff);
            if (idx_ff == 3'(job_ff.delta_len) - 3'd1) begin
               step_state = ST_NOTE_ON;
               step_idx   = '0;
            end
         end
         ST_NOTE_ON: begin
            case (idx_ff)
               3'd0: cur_byte = {STATUS_NOTE_ON, cfg.channel};
               3'd1: cur_byte = {1'b0, job_ff.pitch};
               default: cur_byte = {1'b0, cfg.velocity};
            endcase
            if (idx_ff == 3'd2) begin
               step_state = ST_DUR;
               step_idx   = '0;
            end
         end
         ST_DUR: begin
            cur_byte = vlq_byte(job_ff.dur, job_ff.dur_len, idx_ff);
            if (idx_ff == 3'(job_ff.dur_len) - 3'd1) begin
               step_state = ST_NOTE_OFF;
               step_idx   = '0;
            end
         end
         ST_NOTE_OFF: begin
            case (idx_ff)
               3'd0: cur_byte = {STATUS_NOTE_OFF, cfg.channel};
               3'd1: cur_byte = {1'b0, job_ff.pitch};
               default: cur_byte = ZERO_BYTE;
            endcase
            if (idx_ff == 3'd2) begin
               step_state = ST_EOT;
               step_idx   = '0;
               last_byte  = !job_ff.fin;
            end
         end
         ST_EOT: begin
            case (idx_ff)
               3'd0: cur_byte = ZERO_BYTE;
               3'd1: cur_byte = META_PREFIX;
               3'd2: cur_byte = META_EOT;
               default: cur_byte = ZERO_BYTE;
            endcase
            if (idx_ff == 3'd3) begin
               last_byte = 1'b1;
               done_byte = 1'b1;
            end
         end
         default: begin
            step_state = ST_DELTA;
            step_idx   = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      job_in        = job_ff;
      bytes_sent_in = bytes_sent_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      if (emit) begin
         state_in                = step_state;
         idx_in                  = step_idx;
         rsp_valid_in            = 1'b1;
         rsp_in.out_byte         = cur_byte;
         rsp_in.last_of_run      = last_byte;
         rsp_in.track_done       = done_byte;
         rsp_in.track_length     = done_byte ? bytes_sent_ff + 1'b1 : '0;
         bytes_sent_in           = done_byte ? '0 : bytes_sent_ff + 1'b1;
         if (last_byte) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         job_in   = head_job;
         busy_in  = 1'b1;
         state_in = head_job.tempo_first ? ST_TEMPO : ST_DELTA;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_DELTA;
         idx_ff        <= '0;
         busy_ff       <= 1'b0;
         bytes_sent_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         busy_ff       <= busy_in;
         bytes_sent_ff <= bytes_sent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.track_done |-> rsp_ff.last_of_run)
      else $error("end-of-track byte not marked as last of its item");

   a_length_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.track_done |-> rsp_ff.track_length == '0)
      else $error("track length shown on a byte other than end-of-track");

   a_idx_bounds: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= 3'd6 &&
                  (state_ff != ST_EOT || idx_ff <= 3'd3) &&
                  (state_ff != ST_NOTE_ON || idx_ff <= 3'd2) &&
                  (state_ff != ST_NOTE_OFF || idx_ff <= 3'd2))
      else $error("byte index out of range for sequencer state");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && $past(!reset) |-> $past(emit && last_byte))
      else $error("sequencer went idle without finishing its item");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job taken from an empty queue");

endmodule

// File: hdl/midi_track_event_encoder.sv
// MIDI track event encoder: each accepted note item becomes its track-event
// bytes, one byte per result item. The byte sequencer sends one byte per cycle
// while the result side takes them; a note gives 8 to 23 bytes: 8, plus 1 or
// 2 for each delta longer than one group, plus 7 for the set-tempo event that
// opens a track and 4 for end-of-track after a final note (23 at most). A new job
// is taken in the cycle that finishes the previous one. The front end accepts one
// note per cycle while the queue is not full, into a four-entry queue, so notes
// may arrive while bytes of earlier ones are still going out. A note passes
// the front-end stage, a queue entry and the job register. No clearing pass
// after reset. Depends on mtee_pkg, mtee_front, mtee_queue and mtee_back.
module midi_track_event_encoder
   import mtee_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [TPS_W-1:0]   tps_ff, tps_in;
   logic [VEL_W-1:0]   vel_ff, vel_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;

   cfg_type      cfg;
   q_status_type q_status;
   logic         push, pop;
   job_type      push_job, head_job;

   always_comb begin
      tempo_in = tempo_ff;
      tps_in   = tps_ff;
      vel_in   = vel_ff;
      chan_in  = chan_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEMPO: tempo_in = csr_wdata[TEMPO_W-1:0];
            CSR_TPS:   tps_in   = csr_wdata[TPS_W-1:0];
            CSR_VEL:   vel_in   = csr_wdata[VEL_W-1:0];
            CSR_CHAN:  chan_in  = csr_wdata[CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= TEMPO_RESET;
         tps_ff   <= TPS_RESET;
         vel_ff   <= VEL_RESET;
         chan_ff  <= CHAN_RESET;
      end else begin
         tempo_ff <= tempo_in;
         tps_ff   <= tps_in;
         vel_ff   <= vel_in;
         chan_ff  <= chan_in;
      end
   end

   assign cfg.tempo    = tempo_ff;
   assign cfg.velocity = vel_ff;
   assign cfg.channel  = chan_ff;

   mtee_front #(
      .TIME_FRAC_BITS(TIME_FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .ticks_per_second(tps_ff),
      .q_status        (q_status),
      .push            (push),
      .push_job        (push_job)
   );

   mtee_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .q_status(q_status)
   );

   mtee_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_status (q_status),
      .head_job (head_job),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// File: tb/midi_track_event_encoder_tb.sv
// Self-checking testbench for midi_track_event_encoder: random note items in, track bytes out.
// A scoreboard class predicts every byte from the note and register values it sees accepted.
// Depends on mtee_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module midi_track_event_encoder_tb
   import mtee_pkg::*;
();

   localparam int STALL_LIMIT = 4000;
   localparam int PHASES      = 9;
   localparam int PHASE_NOTES = 42;

   // Predicts the track byte stream and checks the block's bytes against it in order.
   class track_event_ledger;
      rsp_type            pending_bytes[$];
      rsp_type            note_bytes[$];
      int unsigned        error_count;
      logic [TEMPO_W-1:0] tempo;
      logic [TPS_W-1:0]   tick_rate;
      logic [VEL_W-1:0]   velocity;
      logic [CHAN_W-1:0]  channel;
      logic [TICK_W-1:0]  running_tick;
      logic               tempo_due;
      logic [TICK_W-1:0]  track_bytes;

      function new();
         error_count = 0;
         tempo       = TEMPO_RESET;
         tick_rate   = TPS_RESET;
         velocity    = VEL_RESET;
         channel     = CHAN_RESET;
         restore_track();
      endfunction

      function void restore_track();
         running_tick = '0;
         tempo_due    = 1'b1;
         track_bytes  = '0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DAT_W-1:0] value);
         case (idx)
            CSR_TEMPO: tempo     = value[TEMPO_W-1:0];
            CSR_TPS:   tick_rate = value[TPS_W-1:0];
            CSR_VEL:   velocity  = value[VEL_W-1:0];
            CSR_CHAN:  channel   = value[CHAN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TICK_W-1:0] scale_time(input logic [TIME_W-1:0] t);
         logic [TIME_W+TPS_W-1:0] product;
         product = t * tick_rate;
         return TICK_W'(product >> TIME_FRAC_BITS_DEF);
      endfunction

      function void add_byte(input logic [7:0] b);
         rsp_type r;
         r          = '0;
         r.out_byte = b;
         note_bytes = {note_bytes, r};
         track_bytes += 1;
      endfunction

      // Variable-length delta, at most three groups; bits above 20 fall away.
      function void add_delta(input logic [TICK_W-1:0] d);
         if (d < VLQ_ONE_LIMIT) begin
            add_byte({1'b0, d[6:0]});
         end else if (d < VLQ_TWO_LIMIT) begin
            add_byte({1'b1, d[13:7]});
            add_byte({1'b0, d[6:0]});
         end else begin
            add_byte({1'b1, d[20:14]});
            add_byte({1'b1, d[13:7]});
            add_byte({1'b0, d[6:0]});
         end
      endfunction

      function void note_accepted(input req_type n);
         logic [TICK_W-1:0] start_tick;
         logic [TICK_W-1:0] dur_ticks;
         rsp_type           tail;
         note_bytes.delete();
         if (tempo_due) begin
            add_byte(ZERO_BYTE);
            add_byte(META_PREFIX);
            add_byte(META_TEMPO);
            add_byte(TEMPO_DATA_LEN);
            add_byte(tempo[23:16]);
            add_byte(tempo[15:8]);
            add_byte(tempo[7:0]);
            tempo_due = 1'b0;
         end
         start_tick = scale_time(n.start_time);
         dur_ticks  = scale_time(n.note_length);
         add_delta(start_tick - running_tick);
         add_byte({STATUS_NOTE_ON, channel});
         add_byte({1'b0, n.note_pitch});
         add_byte({1'b0, velocity});
         add_delta(dur_ticks);
         add_byte({STATUS_NOTE_OFF, channel});
         add_byte({1'b0, n.note_pitch});
         add_byte(ZERO_BYTE);
         running_tick = start_tick + dur_ticks;
         if (n.final_note) begin
            add_byte(ZERO_BYTE);
            add_byte(META_PREFIX);
            add_byte(META_EOT);
            add_byte(ZERO_BYTE);
            tail              = note_bytes.pop_back();
            tail.track_done   = 1'b1;
            tail.track_length = track_bytes;
            note_bytes        = {note_bytes, tail};
            restore_track();
         end
         tail             = note_bytes.pop_back();
         tail.last_of_run = 1'b1;
         note_bytes       = {note_bytes, tail};
         pending_bytes    = {pending_bytes, note_bytes};
      endfunction

      function void flag(input string field, input logic [TICK_W-1:0] want,
                         input logic [TICK_W-1:0] got);
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      endfunction

      function void check_byte(input rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected byte 0x%0h with nothing pending, expected none",
                     $time, got.out_byte);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            flag("out_byte", TICK_W'(want.out_byte), TICK_W'(got.out_byte));
         end
         if (got.last_of_run !== want.last_of_run) begin
            flag("last_of_run", TICK_W'(want.last_of_run), TICK_W'(got.last_of_run));
         end
         if (got.track_done !== want.track_done) begin
            flag("track_done", TICK_W'(want.track_done), TICK_W'(got.track_done));
         end
         if (got.track_length !== want.track_length) begin
            flag("track_length", want.track_length, got.track_length);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   track_event_ledger ledger = new();
   bit                sender_eager;
   int unsigned       idle_cycles = 0;

   midi_track_event_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: short stalls mostly, a few long ones, and now and then a long open stretch.
   initial begin
      int unsigned pick;
      int unsigned open_len;
      int unsigned stall_len;
      rsp_stall = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            open_len  = $urandom_range(50, 200);
            stall_len = 0;
         end else begin
            open_len  = $urandom_range(0, 8);
            stall_len = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(15, 60);
         end
         repeat (open_len) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         if (open_len + stall_len == 0) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) ledger.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) ledger.note_accepted(req_data);
         if (rsp_valid && !rsp_stall) ledger.check_byte(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("midi_track_event_encoder_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic req_type make_note(input int unsigned pitch, input int unsigned start,
                                         input int unsigned len, input bit fin);
      req_type n;
      n.note_pitch  = pitch[PITCH_W-1:0];
      n.start_time  = start[TIME_W-1:0];
      n.note_length = len[TIME_W-1:0];
      n.final_note  = fin;
      return n;
   endfunction

   // Time span in 1/256 s steps: mostly short, sometimes seconds, rarely the full range.
   function automatic int unsigned random_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(0, 255);
      if (pick < 90) return $urandom_range(256, 4095);
      return $urandom_range(4096, 65535);
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (sender_eager || pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Called at a falling edge; returns at a falling edge after the item is taken.
   task automatic send_note(input req_type n);
      int unsigned gap;
      req_data  <= n;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Always lets at least one falling edge pass, so the next item starts at a later time.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (ledger.pending_bytes.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Narrow registers sometimes get junk in the unused upper bits of the write data.
   task automatic program_registers(input int unsigned tempo, input int unsigned rate,
                                    input int unsigned vel, input int unsigned chan);
      logic [CSR_DAT_W-1:0] junk;
      junk = $urandom_range(0, 1) ? CSR_DAT_W'($urandom) : '0;
      write_reg(CSR_TEMPO, CSR_DAT_W'(tempo));
      write_reg(CSR_TPS, (junk & ~24'h3FF) | CSR_DAT_W'(rate));
      write_reg(CSR_VEL, (junk & ~24'h7F) | CSR_DAT_W'(vel));
      write_reg(CSR_CHAN, (junk & ~24'hF) | CSR_DAT_W'(chan));
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned left;
      int unsigned notes;
      int unsigned pos;
      int unsigned start;
      int unsigned len;
      int unsigned pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_TEMPO;
      csr_wdata   = '0;
      sender_eager = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: widest times, a backwards start, two-group deltas, back-to-back tracks.
      send_note(make_note(0, 0, 0, 0));
      send_note(make_note(127, 16'hFFFF, 16'hFFFF, 0));
      send_note(make_note(64, 0, 1, 0));
      send_note(make_note(5, 16'h0100, 16'h0100, 0));
      send_note(make_note(6, 16'h00A0, 16'h0010, 1));
      send_note(make_note(9, 16'h0020, 16'h0040, 1));
      drain();

      // With 256 ticks per second a tick equals one time step, so delta boundaries are exact.
      program_registers(TEMPO_RESET, 256, VEL_RESET, CHAN_RESET);
      send_note(make_note(1, 16'h007F, 16'h0080, 0));
      send_note(make_note(2, 16'h017F, 16'h3FFF, 0));
      send_note(make_note(3, 16'h817D, 16'h4000, 1));
      send_note(make_note(4, 16'h4000, 16'h007F, 1));

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: program_registers(0, 1, 0, 0);
            1: program_registers(24'hFFFFFF, 1023, 127, 15);
            2: program_registers($urandom_range(0, 24'hFFFFFF), 0, $urandom_range(0, 127),
                                 $urandom_range(0, 15));
            default: program_registers($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 1023),
                                       $urandom_range(0, 127), $urandom_range(0, 15));
         endcase
         sender_eager = ($urandom_range(0, 3) == 0);
         left = PHASE_NOTES;
         while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) drain();
            if (pick < 25) begin
               send_note(make_note($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0));
               left--;
            end else begin
               // Starts step forward from the previous note's end; one past 65535 is redrawn.
               notes = $urandom_range(1, 8);
               pos   = 0;
               for (int k = 0; k < notes && left > 0; k++) begin
                  start = pos + (($urandom_range(0, 3) == 0) ? 0 : random_span());
                  if (start > 65535) start = $urandom_range(0, 65535);
                  len = random_span();
                  send_note(make_note($urandom, start, len, k == notes - 1));
                  pos = start + len;
                  left--;
               end
            end
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (ledger.error_count == 0) begin
         $display("midi_track_event_encoder_tb: done, clean");
      end else begin
         $display("midi_track_event_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule
